// ===== hdl/eid_pkg.sv =====
// Package for the entity id allocator: sizes, status and kind codes,
// and the command word passed from the front end to the back end.
// No dependencies.
package eid_pkg;

    localparam int NUM_IDS   = 1024;
    localparam int MAX_BATCH = 16;

    localparam int ID_W     = $clog2(NUM_IDS);
    localparam int LIVE_W   = $clog2(NUM_IDS + 1);
    localparam int CNT_W    = $clog2(MAX_BATCH + 1);
    localparam int KIND_W   = 2;
    localparam int IN_CNT_W = 5;
    localparam int STAT_W   = 2;

    // Input kind codes; the fourth code is unused and dropped
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BATCH = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FREED = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // One queued command: a single alloc travels as a batch of one
    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
        logic [CNT_W-1:0] n;
    } t_cmd;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

// ===== hdl/eid_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module eid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/eid_front.sv =====
// Front end of the id allocator: accepts input words, drops the ones that
// do nothing, saturates batch sizes and queues commands. Uses eid_pkg.
module eid_front import eid_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [ID_W-1:0]     i_id,
    input  logic [IN_CNT_W-1:0] i_count,
    input  logic                i_clearing,
    output t_qhead              o_head,
    input  logic                i_pop
);

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       accept, keep, push;
    t_cmd       cmd;

    // Classify the incoming word
    always_comb begin
        cmd.op = OP_ALLOC;
        cmd.id = i_id;
        cmd.n  = CNT_W'(1);
        keep   = 1'b0;
        unique case (i_kind)
            KIND_ALLOC: begin
                keep = 1'b1;
            end
            KIND_FREE: begin
                cmd.op = OP_FREE;
                keep   = 1'b1;
            end
            KIND_BATCH: begin
                if (int'(i_count) > MAX_BATCH) begin
                    cmd.n = CNT_W'(MAX_BATCH);
                end else begin
                    cmd.n = CNT_W'(i_count);
                end
                keep = (i_count != '0);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall = i_clearing || (r_cnt == 2'(QDEPTH));
    assign accept  = i_valid && !o_stall;
    assign push    = accept && keep;

    // Two-entry command queue
    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rd];

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt != 2'(QDEPTH)))
        else $error("queue pushed while full");
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clearing |-> !accept)
        else $error("word taken during clearing pass");
`endif

endmodule

// ===== hdl/eid_back.sv =====
// Back end of the id allocator: runs queued commands against the free
// stack and valid-bit RAMs and drives the result register.
// Uses eid_pkg and eid_ram.
module eid_back import eid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qhead            i_head,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ID_W-1:0]   o_granted_id,
    output logic [STAT_W-1:0] o_status,
    output logic              o_last,
    output logic [LIVE_W-1:0] o_live_count
);

    localparam int SUM_W = LIVE_W + 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FREE  = 4'b0100,
        S_BATCH = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [ID_W-1:0]   r_clr, n_clr;
    logic [LIVE_W-1:0] r_depth, n_depth;
    logic [LIVE_W-1:0] r_hw, n_hw;
    logic [LIVE_W-1:0] r_live, n_live;
    logic [ID_W-1:0]   r_fid, n_fid;
    logic [ID_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_rd_left, n_rd_left;
    logic [CNT_W-1:0]  r_emit_left, n_emit_left;
    logic              r_pend, n_pend;

    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_gid;
    t_status           r_out_status;
    logic              r_out_last;
    logic [LIVE_W-1:0] r_out_live;

    logic              emit;
    logic [ID_W-1:0]   e_gid;
    t_status           e_status;
    logic              e_last;
    logic [LIVE_W-1:0] e_live;

    logic              vb_we, vb_wdata, vb_re, vb_rdata;
    logic [ID_W-1:0]   vb_waddr, vb_raddr;
    logic              fs_we, fs_re;
    logic [ID_W-1:0]   fs_waddr, fs_raddr, fs_wdata, fs_rdata;

    logic              out_free;
    logic [CNT_W-1:0]  from_stack;
    logic [LIVE_W-1:0] base;
    logic [SUM_W-1:0]  avail;
    logic              full, fresh, have_res;

    assign out_free = !r_out_valid || !i_stall;

    // Batch split: how many ids come off the stack, and whether it fits
    always_comb begin
        if (r_depth > LIVE_W'(i_head.cmd.n)) begin
            from_stack = i_head.cmd.n;
        end else begin
            from_stack = CNT_W'(r_depth);
        end
        base  = r_depth - LIVE_W'(from_stack);
        avail = SUM_W'(r_depth) + SUM_W'(NUM_IDS) - SUM_W'(r_hw);
        full  = avail < SUM_W'(i_head.cmd.n);
    end

    assign fresh    = !r_pend && (r_rd_left == '0);
    assign have_res = r_pend || fresh;

    // Command sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_depth     = r_depth;
        n_hw        = r_hw;
        n_live      = r_live;
        n_fid       = r_fid;
        n_ptr       = r_ptr;
        n_rd_left   = r_rd_left;
        n_emit_left = r_emit_left;
        n_pend      = r_pend;
        o_pop       = 1'b0;
        emit        = 1'b0;
        e_gid       = '0;
        e_status    = ST_OK;
        e_last      = 1'b1;
        e_live      = r_live;
        vb_we       = 1'b0;
        vb_waddr    = r_fid;
        vb_wdata    = 1'b0;
        vb_re       = 1'b0;
        vb_raddr    = i_head.cmd.id;
        fs_we       = 1'b0;
        fs_waddr    = r_depth[ID_W-1:0];
        fs_wdata    = r_fid;
        fs_re       = 1'b0;
        fs_raddr    = r_ptr;

        unique case (r_state)
            // Zero every valid bit once after reset
            S_CLEAR: begin
                vb_we    = 1'b1;
                vb_waddr = r_clr;
                vb_wdata = 1'b0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == ID_W'(NUM_IDS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.cmd.op == OP_FREE) begin
                        if (LIVE_W'(i_head.cmd.id) >= r_hw) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                e_gid    = i_head.cmd.id;
                                e_status = ST_RANGE;
                                o_pop    = 1'b1;
                            end
                        end else begin
                            vb_re   = 1'b1;
                            n_fid   = i_head.cmd.id;
                            o_pop   = 1'b1;
                            n_state = S_FREE;
                        end
                    end else if (full) begin
                        if (out_free) begin
                            emit     = 1'b1;
                            e_status = ST_FULL;
                            o_pop    = 1'b1;
                        end
                    end else begin
                        o_pop       = 1'b1;
                        n_depth     = base;
                        n_emit_left = i_head.cmd.n;
                        n_state     = S_BATCH;
                        if (from_stack != '0) begin
                            fs_re     = 1'b1;
                            fs_raddr  = base[ID_W-1:0];
                            n_ptr     = base[ID_W-1:0] + 1'b1;
                            n_rd_left = from_stack - 1'b1;
                            n_pend    = 1'b1;
                        end else begin
                            n_rd_left = '0;
                            n_pend    = 1'b0;
                        end
                    end
                end
            end

            // Valid bit of the id being freed is on vb_rdata
            S_FREE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_gid   = r_fid;
                    n_state = S_IDLE;
                    if (!vb_rdata) begin
                        e_status = ST_FREED;
                    end else begin
                        vb_we    = 1'b1;
                        vb_wdata = 1'b0;
                        fs_we    = 1'b1;
                        n_depth  = r_depth + 1'b1;
                        n_live   = r_live - 1'b1;
                        e_live   = r_live - 1'b1;
                    end
                end
            end

            // One id per cycle while the result register is not stalled: stack entries bottom first, then fresh ids
            S_BATCH: begin
                if (have_res && out_free) begin
                    emit        = 1'b1;
                    e_gid       = r_pend ? fs_rdata : r_hw[ID_W-1:0];
                    e_last      = (r_emit_left == CNT_W'(1));
                    e_live      = r_live + 1'b1;
                    n_live      = r_live + 1'b1;
                    n_emit_left = r_emit_left - 1'b1;
                    vb_we       = 1'b1;
                    vb_waddr    = e_gid;
                    vb_wdata    = 1'b1;
                    if (fresh) begin
                        n_hw = r_hw + 1'b1;
                    end
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
                if ((r_rd_left != '0) && (!r_pend || emit)) begin
                    fs_re     = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                    n_rd_left = r_rd_left - 1'b1;
                    n_pend    = 1'b1;
                end else if (emit) begin
                    n_pend = 1'b0;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_depth     <= '0;
            r_hw        <= '0;
            r_live      <= '0;
            r_rd_left   <= '0;
            r_emit_left <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_depth     <= n_depth;
            r_hw        <= n_hw;
            r_live      <= n_live;
            r_rd_left   <= n_rd_left;
            r_emit_left <= n_emit_left;
            r_pend      <= n_pend;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fid <= n_fid;
        r_ptr <= n_ptr;
        if (emit) begin
            r_out_gid    <= e_gid;
            r_out_status <= e_status;
            r_out_last   <= e_last;
            r_out_live   <= e_live;
        end
    end

    eid_ram #(.WIDTH(1), .DEPTH(NUM_IDS)) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (vb_we),
        .i_waddr (vb_waddr),
        .i_wdata (vb_wdata),
        .i_re    (vb_re),
        .i_raddr (vb_raddr),
        .o_rdata (vb_rdata)
    );

    eid_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_re    (fs_re),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    assign o_clearing   = (r_state == S_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_granted_id = r_out_gid;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;
    assign o_live_count = r_out_live;

`ifndef SYNTH
    // Every id below the mark is either live or on the stack
    a_live_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_live == r_hw - r_depth))
        else $error("live count out of balance with mark and stack");
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head.valid)
        else $error("pop without a queued command");
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FULL)) |-> (r_out_last && (r_out_gid == '0)))
        else $error("full status word malformed");
    a_batch_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BATCH) |-> (r_emit_left != '0))
        else $error("batch running with nothing left to emit");
    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hw <= LIVE_W'(NUM_IDS)) && (r_depth <= r_hw))
        else $error("mark or stack depth out of range");
`endif

endmodule

// ===== hdl/entity_id_allocator.sv =====
// Top level of the entity id allocator: front end with command queue and
// back end with free stack and valid bits. Uses eid_pkg, eid_front, eid_back.
//
//   channel  direction  handshake          fields
//   input    in         i_valid / o_stall  i_kind, i_id, i_count
//   result   out        o_valid / i_stall  o_granted_id, o_status, o_last, o_live_count
//
// A free reads the valid-bit RAM, then does the update and result.
// A free at or above the mark and a full answer are answered straight from idle.
// A single alloc runs as a batch of one; a batch gives one result a cycle while
// the result register is not stalled, paced by the registered read of the free stack RAM.
// After reset a clearing pass zeroes all NUM_IDS (1024) valid bits;
// o_stall is high throughout. A two-entry queue lets the front keep taking
// words while the result register waits on i_stall.
module entity_id_allocator import eid_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [ID_W-1:0]     i_id,
    input  logic [IN_CNT_W-1:0] i_count,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ID_W-1:0]     o_granted_id,
    output logic [STAT_W-1:0]   o_status,
    output logic                o_last,
    output logic [LIVE_W-1:0]   o_live_count
);

    t_qhead head;
    logic   pop;
    logic   clearing;

    eid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_id       (i_id),
        .i_count    (i_count),
        .i_clearing (clearing),
        .o_head     (head),
        .i_pop      (pop)
    );

    eid_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_granted_id (o_granted_id),
        .o_status     (o_status),
        .o_last       (o_last),
        .o_live_count (o_live_count)
    );

endmodule

// ===== tb/eid_result_checker.sv =====
// Result checker for the entity id allocator: watches both channels, predicts the
// granted ids, statuses and live counts, and compares them in order.
// Depends on eid_pkg.
module eid_result_checker import eid_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [ID_W-1:0]     i_id,
    input  logic [IN_CNT_W-1:0] i_count,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [ID_W-1:0]     i_granted_id,
    input  logic [STAT_W-1:0]   i_status,
    input  logic                i_last,
    input  logic [LIVE_W-1:0]   i_live_count,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ID_W-1:0]   gid;
        t_status           st;
        logic              last;
        logic [LIVE_W-1:0] live;
    } t_grant;

    // Expected grants, oldest first
    t_grant grant_q[$];
    t_grant want;

    // Shadow allocator state
    bit              id_live [NUM_IDS];
    logic [ID_W-1:0] stk_ids [NUM_IDS];
    int unsigned     n_free     = 0;
    int unsigned     next_fresh = 0;
    int unsigned     n_live     = 0;
    int              n_fail     = 0;

    function automatic void push_grant(logic [ID_W-1:0] gid, t_status st, logic last);
        t_grant g;
        g.gid  = gid;
        g.st   = st;
        g.last = last;
        g.live = LIVE_W'(n_live);
        grant_q.insert(grant_q.size(), g);
    endfunction

    function automatic void take_id(logic [ID_W-1:0] gid);
        id_live[gid] = 1'b1;
        n_live++;
    endfunction

    // Work out the grants caused by one accepted word
    function automatic void predict_grants(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                           logic [IN_CNT_W-1:0] cnt);
        int unsigned     n;
        int unsigned     from_stk;
        int unsigned     base;
        int unsigned     i;
        logic [ID_W-1:0] gid;
        case (kind)
            KIND_ALLOC: begin
                if (n_free > 0) begin
                    n_free--;
                    gid = stk_ids[n_free];
                    take_id(gid);
                    push_grant(gid, ST_OK, 1'b1);
                end else if (next_fresh < NUM_IDS) begin
                    gid = ID_W'(next_fresh);
                    next_fresh++;
                    take_id(gid);
                    push_grant(gid, ST_OK, 1'b1);
                end else begin
                    push_grant('0, ST_FULL, 1'b1);
                end
            end
            KIND_FREE: begin
                if (id >= next_fresh) begin
                    push_grant(id, ST_RANGE, 1'b1);
                end else if (!id_live[id]) begin
                    push_grant(id, ST_FREED, 1'b1);
                end else begin
                    id_live[id]     = 1'b0;
                    stk_ids[n_free] = id;
                    n_free++;
                    n_live--;
                    push_grant(id, ST_OK, 1'b1);
                end
            end
            KIND_BATCH: begin
                n = (cnt > MAX_BATCH) ? MAX_BATCH : cnt;
                if (n != 0) begin
                    if (n_free + NUM_IDS - next_fresh < n) begin
                        push_grant('0, ST_FULL, 1'b1);
                    end else begin
                        // stack part goes out bottom first, then fresh ids
                        from_stk = (n_free > n) ? n : n_free;
                        base     = n_free - from_stk;
                        for (i = 0; i < n; i++) begin
                            if (i < from_stk) begin
                                gid = stk_ids[base + i];
                            end else begin
                                gid = ID_W'(next_fresh);
                                next_fresh++;
                            end
                            take_id(gid);
                            push_grant(gid, ST_OK, i == n - 1);
                        end
                        n_free = base;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_val,
                                        logic [15:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            n_fail++;
        end
    endfunction

    // Sample both channels at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                predict_grants(i_kind, i_id, i_count);
            end
            if (i_out_valid && !i_out_stall) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected result word: granted_id %0d status %0d",
                           i_granted_id, i_status);
                    n_fail++;
                end else begin
                    want = grant_q.pop_front();
                    check_field("granted_id", 16'(want.gid), 16'(i_granted_id));
                    check_field("status", 16'(want.st), 16'(i_status));
                    check_field("last", 16'(want.last), 16'(i_last));
                    check_field("live_count", 16'(want.live), 16'(i_live_count));
                end
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= grant_q.size();
    end

endmodule

// ===== tb/tb_entity_id_allocator.sv =====
// Testbench top for the entity id allocator: clock, reset, word stimulus and
// receiver stalls; eid_result_checker does the checking. Depends on eid_pkg.
module tb_entity_id_allocator import eid_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_WORDS  = 32;
    localparam int LIMIT_NS     = 2_000_000;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [KIND_W-1:0]   i_kind  = KIND_ALLOC;
    logic [ID_W-1:0]     i_id    = '0;
    logic [IN_CNT_W-1:0] i_count = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [ID_W-1:0]     o_granted_id;
    logic [STAT_W-1:0]   o_status;
    logic                o_last;
    logic [LIVE_W-1:0]   o_live_count;

    int   fail_count;
    int   pending;
    int   snd_pct = 0;
    int   rcv_pct = 0;
    logic hold_on = 1'b0;
    int   est_hw  = 0;

    entity_id_allocator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_id         (i_id),
        .i_count      (i_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_granted_id (o_granted_id),
        .o_status     (o_status),
        .o_last       (o_last),
        .o_live_count (o_live_count)
    );

    eid_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_kind       (i_kind),
        .i_id         (i_id),
        .i_count      (i_count),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_granted_id (o_granted_id),
        .i_status     (o_status),
        .i_last       (o_last),
        .i_live_count (o_live_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one word after random idle cycles; return once it is taken
    task automatic send_word(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                             input logic [IN_CNT_W-1:0] n);
        while ($urandom_range(0, 99) < snd_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= k;
        i_id    <= id;
        i_count <= n;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        // rough upper bound on the high-water mark, used to aim frees
        case (k)
            KIND_ALLOC: est_hw++;
            KIND_BATCH: est_hw += (n > MAX_BATCH) ? MAX_BATCH : n;
            default: ;
        endcase
        if (est_hw > NUM_IDS) est_hw = NUM_IDS;
    endtask

    task automatic send_random_word();
        int                  r;
        logic [ID_W-1:0]     id;
        logic [IN_CNT_W-1:0] n;
        r  = $urandom_range(0, 99);
        id = ID_W'($urandom_range(0, NUM_IDS - 1));
        n  = IN_CNT_W'($urandom_range(0, 31));
        if (r < 34) begin
            send_word(KIND_ALLOC, id, n);
        end else if (r < 70) begin
            // mostly ids below the mark so the valid bits get exercised
            if ($urandom_range(0, 9) < 7 && est_hw > 0) begin
                id = ID_W'($urandom_range(0, est_hw - 1));
            end
            send_word(KIND_FREE, id, n);
        end else if (r < 96) begin
            if ($urandom_range(0, 9) < 8) n = IN_CNT_W'($urandom_range(1, MAX_BATCH));
            send_word(KIND_BATCH, id, n);
        end else begin
            send_word(KIND_UNUSED, id, n);
        end
    endtask

    // Stop offering and wait for every expected result
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct);
        snd_pct = s_pct;
        rcv_pct <= r_pct;
        repeat (PHASE_WORDS) send_random_word();
        drain();
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : rcv_proc
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_on) begin
                hold_seen = 1'b0;
            end else if (!hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rcv_pct);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: range, double free, stack reuse, batch split and limits
        send_word(KIND_FREE, 10'd0, 5'd0);
        send_word(KIND_ALLOC, 10'h3FF, 5'h1F);
        send_word(KIND_FREE, 10'd0, 5'd0);
        send_word(KIND_FREE, 10'd0, 5'd0);
        send_word(KIND_ALLOC, 10'd0, 5'd0);
        send_word(KIND_BATCH, 10'd0, 5'd0);
        send_word(KIND_UNUSED, 10'h3FF, 5'h1F);
        send_word(KIND_BATCH, 10'd0, 5'd1);
        send_word(KIND_BATCH, 10'd0, 5'd16);
        send_word(KIND_BATCH, 10'h3FF, 5'd31);
        send_word(KIND_FREE, 10'd5, 5'd0);
        send_word(KIND_FREE, 10'd7, 5'd0);
        send_word(KIND_FREE, 10'd9, 5'd0);
        send_word(KIND_BATCH, 10'd0, 5'd2);
        send_word(KIND_BATCH, 10'd0, 5'd3);
        send_word(KIND_FREE, 10'h3FF, 5'd0);
        send_word(KIND_FREE, 10'd1000, 5'd0);
        send_word(KIND_FREE, 10'd34, 5'd0);
        send_word(KIND_ALLOC, 10'd0, 5'd0);
        drain();

        run_phase(0, 0);

        // exhaust every id so both allocation kinds hit full
        snd_pct = 34;
        rcv_pct <= 34;
        repeat (66) send_word(KIND_BATCH, ID_W'($urandom_range(0, NUM_IDS - 1)), 5'd16);
        repeat (16) send_word(KIND_ALLOC, ID_W'($urandom_range(0, NUM_IDS - 1)),
                              IN_CNT_W'($urandom_range(0, 31)));
        drain();

        run_phase(59, 0);
        run_phase(0, 59);
        run_phase(34, 34);

        // long receiver hold-off while words keep coming
        snd_pct = 0;
        rcv_pct <= 0;
        hold_on <= 1'b1;
        repeat (12) send_random_word();
        hold_on <= 1'b0;
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("entity_id_allocator verification clean");
        end else begin
            $display("entity_id_allocator verification failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("entity_id_allocator verification failed");
        $finish;
    end

endmodule
